[src/rgb565_saturation_boost_assert.svh]
// ============================================================================
// Assertion macros for the RGB565 saturation boost block
// Checks are compiled out when NO_ASSERTIONS is defined.
// ============================================================================
`ifndef RGB565_SATURATION_BOOST_ASSERT_SVH
`define RGB565_SATURATION_BOOST_ASSERT_SVH
`ifndef NO_ASSERTIONS
// Antecedent implies consequent in the same cycle.
`define RSB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rgb565_saturation_boost: implication check failed");
// Antecedent implies consequent a fixed number of cycles later.
`define RSB_ASSERT_DELAY(label, clk, rst_n, ante, lat, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##lat (cons)) \
        else $error("rgb565_saturation_boost: delayed check failed");
`else
`define RSB_ASSERT_IMPLY(label, clk, rst_n, ante, cons)
`define RSB_ASSERT_DELAY(label, clk, rst_n, ante, lat, cons)
`endif
`endif

[src/rsb_pkg.sv]
// ============================================================================
// rsb_pkg
// Types and constants shared by the RGB565 saturation boost pipeline.
// ============================================================================
`default_nettype none

package rsb_pkg;

    // Number of color channels; index 2 is red, 1 is green, 0 is blue.
    localparam int unsigned NUM_CH = 3;

    // Configuration register indexes.
    typedef enum logic [0:0] {
        CFG_GAIN  = 1'b0,
        CFG_LIMIT = 1'b1
    } rsb_cfg_idx_t;

    // Reset values of the configuration registers.
    localparam logic [7:0] GAIN_RESET  = 8'd160;
    localparam logic [6:0] LIMIT_RESET = 7'd85;

    // Colors whose spread is at or below this pass through untouched.
    localparam logic [7:0] GRAY_SPREAD_MAX = 8'd8;
    // Margin taken off the limit, in percent.
    localparam logic [6:0] MARGIN_PERCENT = 7'd3;
    // Rounding offset for a divide by 100.
    localparam logic [5:0] PERCENT_HALF = 6'd50;

    // Divide by 100 as multiply by ceil(2^23 / 100) and shift by 23.
    // Exact for all dividends below 2^16.
    localparam int unsigned DIV100_SHIFT = 23;
    localparam logic [16:0] DIV100_MUL   = 17'd83887;

    // Divide by the spread as multiply by ceil(2^25 / spread) and shift by 25.
    // Exact for dividends below 2^17 and spreads up to 255.
    localparam int unsigned RECIP_SHIFT = 25;
    localparam int unsigned RECIP_W     = 22;

    // First stage word: channel statistics.
    typedef struct packed {
        logic                     pass;
        logic [15:0]              pixel;
        logic [7:0]               top;
        logic [7:0]               spread;
        logic [NUM_CH-1:0][7:0]   gap;
    } rsb_stat_t;

    // Word after the spread scaling: target spread and reciprocal.
    typedef struct packed {
        logic                     pass;
        logic [15:0]              pixel;
        logic [7:0]               top;
        logic [7:0]               spread;
        logic [NUM_CH-1:0][7:0]   gap;
        logic [8:0]               new_spread;
        logic [RECIP_W-1:0]       recip;
    } rsb_scale_t;

endpackage

`default_nettype wire

[src/rgb565_saturation_boost.sv]
// ============================================================================
// rgb565_saturation_boost
// Boosts the saturation of one RGB565 color per clock.
// ============================================================================
// Usage:
//   Input: drive pixel_in and raise start; the word is taken at any rising
//   edge with start high and busy low. busy stays low, so a new color can
//   enter on every clock.
//   Output: each result is on pixel_out for exactly one cycle, marked by
//   done. Results come out in input order, one for every color taken.
//   Pipeline: a color taken passes through six pipeline registers
//   (statistics, gain products, divide by 100, distance products,
//   reciprocal divide, output) before it is shown on pixel_out.
//   Throughput is one color per cycle, set by the fully pipelined multipliers.
//   Configuration: cfg_we writes cfg_data to register cfg_index at a rising
//   edge (0: gain_percent, 1: limit_percent). Write only while no color is
//   in flight.
//   Reset: rst_n clears the pipeline valid bits and loads gain_percent with
//   160 and limit_percent with 85. The receiver cannot stall the block.
// ============================================================================
`default_nettype none

`include "rgb565_saturation_boost_assert.svh"

module rgb565_saturation_boost
    import rsb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        start,
    output logic             busy,
    input  wire logic        cfg_we,
    input  wire logic [0:0]  cfg_index,
    input  wire logic [7:0]  cfg_data,
    input  wire logic [15:0] pixel_in,
    output logic             done,
    output logic [15:0]      pixel_out
);

    logic [7:0] gain_reg;
    logic [7:0] gain_next;
    logic [6:0] limit_reg;
    logic [6:0] limit_next;
    logic       in_valid;
    logic       stat_valid;
    rsb_stat_t  stat;
    logic       scale_valid;
    rsb_scale_t scale;

    // The pipeline never stalls.
    assign busy     = 1'b0;
    assign in_valid = start && !busy;

    // Configuration register write decode.
    always_comb
    begin
        gain_next  = gain_reg;
        limit_next = limit_reg;
        if (cfg_we)
        begin
            case (rsb_cfg_idx_t'(cfg_index))
                CFG_GAIN:  gain_next  = cfg_data;
                CFG_LIMIT: limit_next = cfg_data[6:0];
                default:   gain_next  = gain_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg  <= GAIN_RESET;
            limit_reg <= LIMIT_RESET;
        end
        else
        begin
            gain_reg  <= gain_next;
            limit_reg <= limit_next;
        end
    end

    rsb_prep u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .pixel_in   (pixel_in),
        .stat_valid (stat_valid),
        .stat       (stat)
    );

    rsb_spread u_spread (
        .clk           (clk),
        .rst_n         (rst_n),
        .stat_valid    (stat_valid),
        .stat          (stat),
        .gain_percent  (gain_reg),
        .limit_percent (limit_reg),
        .scale_valid   (scale_valid),
        .scale         (scale)
    );

    rsb_chan u_chan (
        .clk         (clk),
        .rst_n       (rst_n),
        .scale_valid (scale_valid),
        .scale       (scale),
        .done        (done),
        .pixel_out   (pixel_out)
    );

    // Every accepted word comes out at the end of the pipeline, marked by done.
    `RSB_ASSERT_DELAY(a_latency, clk, rst_n, start && !busy, 6, done)
    // No result appears without a matching word taken at the input.
    `RSB_ASSERT_IMPLY(a_no_phantom, clk, rst_n, done, $past(start && !busy, 6))
    // Black passes through as black.
    `RSB_ASSERT_DELAY(a_black_pass, clk, rst_n, in_valid && (pixel_in == 16'h0), 6, pixel_out == 16'h0)

endmodule

`default_nettype wire

[src/rsb_prep.sv]
// ============================================================================
// rsb_prep
// Expands RGB565 to 8 bits per channel and registers max, spread and distances.
// ============================================================================
`default_nettype none

module rsb_prep
    import rsb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic [15:0] pixel_in,
    output logic             stat_valid,
    output rsb_stat_t        stat
);

    logic [NUM_CH-1:0][7:0] chan;
    logic [7:0]             max_rg;
    logic [7:0]             min_rg;
    logic [7:0]             top;
    logic [7:0]             bot;
    logic                   valid_reg;
    rsb_stat_t              stat_reg;
    rsb_stat_t              stat_next;

    // Bit replication to 8 bits per channel.
    assign chan[2] = {pixel_in[15:11], pixel_in[15:13]};
    assign chan[1] = {pixel_in[10:5], pixel_in[10:9]};
    assign chan[0] = {pixel_in[4:0], pixel_in[4:2]};

    // Maximum and minimum of the three channels.
    always_comb
    begin
        max_rg = (chan[2] > chan[1]) ? chan[2] : chan[1];
        min_rg = (chan[2] < chan[1]) ? chan[2] : chan[1];
        top    = (max_rg > chan[0]) ? max_rg : chan[0];
        bot    = (min_rg < chan[0]) ? min_rg : chan[0];
    end

    // Statistics word for the next stage.
    always_comb
    begin
        stat_next.pixel  = pixel_in;
        stat_next.top    = top;
        stat_next.spread = top - bot;
        stat_next.pass   = ((top - bot) <= GRAY_SPREAD_MAX) || (top == 8'd0);
        for (int c = 0; c < NUM_CH; c++)
        begin
            stat_next.gap[c] = top - chan[c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        stat_reg <= stat_next;
    end

    assign stat_valid = valid_reg;
    assign stat       = stat_reg;

endmodule

`default_nettype wire

[src/rsb_spread.sv]
// ============================================================================
// rsb_spread
// Scales the spread by the gain, caps it against the limit, and looks up the
// reciprocal of the old spread. Two register stages.
// ============================================================================
`default_nettype none

module rsb_spread
    import rsb_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       stat_valid,
    input  wire rsb_stat_t  stat,
    input  wire logic [7:0] gain_percent,
    input  wire logic [6:0] limit_percent,
    output logic            scale_valid,
    output rsb_scale_t      scale
);

    logic [RECIP_W-1:0] recip_tab [256];
    logic [6:0]         lim_eff;
    logic [15:0]        gain_sum_next;
    logic [14:0]        cap_sum_next;

    logic               a_valid_reg;
    rsb_stat_t          a_stat_reg;
    logic [15:0]        a_gain_sum_reg;
    logic [14:0]        a_cap_sum_reg;
    logic [RECIP_W-1:0] a_recip_reg;

    logic [32:0]        gain_prod;
    logic [32:0]        cap_prod;
    logic [9:0]         gain_q;
    logic [8:0]         cap_q;
    logic               b_valid_reg;
    rsb_scale_t         scale_reg;
    rsb_scale_t         scale_next;

    // Reciprocal table of the spread; spreads that pass through read zero.
    for (genvar d = 0; d < 256; d++)
    begin : g_recip
        localparam int unsigned DIV   = (d == 0) ? 1 : d;
        localparam int unsigned RECIP = (d <= int'(GRAY_SPREAD_MAX)) ? 0 :
                                        (((1 << RECIP_SHIFT) + DIV - 1) / DIV);
        assign recip_tab[d] = RECIP_W'(RECIP);
    end

    // Stage A: gain and cap products with rounding offset.
    always_comb
    begin
        lim_eff       = (limit_percent > MARGIN_PERCENT) ?
                        (limit_percent - MARGIN_PERCENT) : 7'd0;
        gain_sum_next = 16'(16'(stat.spread) * 16'(gain_percent)) + 16'(PERCENT_HALF);
        cap_sum_next  = 15'(15'(stat.top) * 15'(lim_eff)) + 15'(PERCENT_HALF);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
        end
        else
        begin
            a_valid_reg <= stat_valid;
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        a_stat_reg     <= stat;
        a_gain_sum_reg <= gain_sum_next;
        a_cap_sum_reg  <= cap_sum_next;
        a_recip_reg    <= recip_tab[stat.spread];
    end

    // Stage B: both divides by 100, then the smaller of the two spreads.
    always_comb
    begin
        gain_prod = 33'(a_gain_sum_reg) * 33'(DIV100_MUL);
        cap_prod  = 33'(a_cap_sum_reg) * 33'(DIV100_MUL);
        gain_q    = gain_prod[DIV100_SHIFT +: 10];
        cap_q     = cap_prod[DIV100_SHIFT +: 9];

        scale_next.pass       = a_stat_reg.pass;
        scale_next.pixel      = a_stat_reg.pixel;
        scale_next.top        = a_stat_reg.top;
        scale_next.spread     = a_stat_reg.spread;
        scale_next.gap        = a_stat_reg.gap;
        scale_next.recip      = a_recip_reg;
        scale_next.new_spread = ({1'b0, cap_q} < gain_q) ? cap_q : gain_q[8:0];
    end

    always_ff @(posedge clk)
    begin
        scale_reg <= scale_next;
    end

    assign scale_valid = b_valid_reg;
    assign scale       = scale_reg;

endmodule

`default_nettype wire

[src/rsb_chan.sv]
// ============================================================================
// rsb_chan
// Rescales each channel's distance from the maximum and packs the RGB565
// result. Three register stages; the last one drives the result ports.
// ============================================================================
`default_nettype none

module rsb_chan
    import rsb_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        scale_valid,
    input  wire rsb_scale_t  scale,
    output logic             done,
    output logic [15:0]      pixel_out
);

    logic [NUM_CH-1:0][16:0] num_next;
    logic [NUM_CH-1:0][16:0] num_reg;
    logic [NUM_CH-1:0][38:0] prod;
    logic [NUM_CH-1:0][13:0] scaled_next;
    logic [NUM_CH-1:0][13:0] scaled_reg;
    logic [NUM_CH-1:0][7:0]  chan_new;

    logic                    c_valid_reg;
    logic                    c_pass_reg;
    logic [15:0]             c_pixel_reg;
    logic [7:0]              c_top_reg;
    logic [RECIP_W-1:0]      c_recip_reg;

    logic                    d_valid_reg;
    logic                    d_pass_reg;
    logic [15:0]             d_pixel_reg;
    logic [7:0]              d_top_reg;

    logic                    out_valid_reg;
    logic [15:0]             pixel_next;
    logic [15:0]             pixel_reg;

    for (genvar c = 0; c < NUM_CH; c++)
    begin : g_chan
        // Stage C: distance times new spread, plus half the old spread.
        assign num_next[c] = 17'(17'(scale.gap[c]) * 17'(scale.new_spread))
                             + 17'(scale.spread[7:1]);
        // Stage D: divide by the old spread through its reciprocal.
        assign prod[c]        = 39'(num_reg[c]) * 39'(c_recip_reg);
        assign scaled_next[c] = prod[c][RECIP_SHIFT +: 14];
        // Stage E: step down from the maximum, floor at zero.
        assign chan_new[c]    = (scaled_reg[c] > 14'(d_top_reg)) ? 8'd0 :
                                (d_top_reg - scaled_reg[c][7:0]);
    end

    // Truncate back to 5/6/5 bits, or pass the input through.
    assign pixel_next = d_pass_reg ? d_pixel_reg :
                        {chan_new[2][7:3], chan_new[1][7:2], chan_new[0][7:3]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            c_valid_reg   <= 1'b0;
            d_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            c_valid_reg   <= scale_valid;
            d_valid_reg   <= c_valid_reg;
            out_valid_reg <= d_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg     <= num_next;
        c_pass_reg  <= scale.pass;
        c_pixel_reg <= scale.pixel;
        c_top_reg   <= scale.top;
        c_recip_reg <= scale.recip;

        scaled_reg  <= scaled_next;
        d_pass_reg  <= c_pass_reg;
        d_pixel_reg <= c_pixel_reg;
        d_top_reg   <= c_top_reg;

        pixel_reg   <= pixel_next;
    end

    assign done      = out_valid_reg;
    assign pixel_out = pixel_reg;

endmodule

`default_nettype wire
